### hdl/hbd_pkg.sv
`default_nettype none

package hbd_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W         = 16;
    localparam int MAG_W         = 15;
    localparam int TIMER_W       = 24;
    localparam int DUTY_FIELD_W  = 10;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 24;

    // Duty scaling constants
    localparam int HBD_DUTY_MAX   = 1023;
    localparam int FULL_SCALE     = 32767;
    localparam int HALF_SCALE     = 16383;
    localparam int DUTY_FIELD_MAX = 1023;

    typedef enum logic [1:0] {
        KIND_TICK        = 2'd0,
        KIND_DRIVE       = 2'd1,
        KIND_FAULT_STOP  = 2'd2,
        KIND_CLEAR_FAULT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_APPLIED      = 2'd0,
        STAT_REJECTED     = 2'd1,
        STAT_WAIT_NEUTRAL = 2'd2,
        STAT_NONE         = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FWD_RPWM      = 2'd0,
        CFG_LEASE_TIMEOUT = 2'd1,
        CFG_NEUTRAL_DELAY = 2'd2
    } cfg_index_t;

    // Decoded input request held in the input register
    typedef struct packed {
        kind_t kind;
        logic  cmd_zero;
        dir_t  dir;
    } item_t;

    // Configuration registers as seen by the controller
    typedef struct packed {
        logic               fwd_rpwm;
        logic [TIMER_W-1:0] lease_timeout;
        logic [TIMER_W-1:0] neutral_delay;
    } cfg_t;

    // One result request
    typedef struct packed {
        logic                    bridge_enable;
        logic [DUTY_FIELD_W-1:0] right_duty;
        logic [DUTY_FIELD_W-1:0] left_duty;
        status_t                 status;
        logic                    expired_flag;
        logic                    fault_flag;
    } result_t;

endpackage

`default_nettype wire

### hdl/hbd_duty_scale.sv
`default_nettype none

module hbd_duty_scale
    import hbd_pkg::*;
#(
    parameter int DUTY_MAX = HBD_DUTY_MAX
) (
    input  wire logic [MAG_W+$clog2(DUTY_MAX+1)-1:0] product,
    output logic [DUTY_FIELD_W-1:0]                  duty
);

    localparam int DUTY_W = $clog2(DUTY_MAX + 1);
    localparam int PROD_W = MAG_W + DUTY_W;
    localparam int X_W    = PROD_W + 1;
    localparam int A_W    = X_W - MAG_W;
    localparam int SUM_W  = ((A_W > MAG_W) ? A_W : MAG_W) + 2;
    localparam int Q_W    = ((A_W > DUTY_FIELD_W) ? A_W : DUTY_FIELD_W) + 1;

    logic [X_W-1:0]   x;
    logic [A_W-1:0]   a;
    logic [MAG_W-1:0] b;
    logic [SUM_W-1:0] s;
    logic [1:0]       extra;
    logic [Q_W-1:0]   q;

    // Round half up, then divide by 2^15-1: x = a*2^15 + b = a*32767 + (a + b)
    always_comb begin
        x = {1'b0, product} + X_W'(HALF_SCALE);
        a = x[X_W-1:MAG_W];
        b = x[MAG_W-1:0];
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(3 * FULL_SCALE)) begin
            extra = 2'd3;
        end else if (s >= SUM_W'(2 * FULL_SCALE)) begin
            extra = 2'd2;
        end else if (s >= SUM_W'(FULL_SCALE)) begin
            extra = 2'd1;
        end else begin
            extra = 2'd0;
        end
        q = Q_W'(a) + Q_W'(extra);
        // Saturate at the field maximum
        if (q > Q_W'(DUTY_FIELD_MAX)) begin
            duty = DUTY_FIELD_W'(DUTY_FIELD_MAX);
        end else begin
            duty = q[DUTY_FIELD_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hdl/hbd_ctrl.sv
`default_nettype none

module hbd_ctrl
    import hbd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    fire,
    input  wire item_t                   item,
    input  wire logic [DUTY_FIELD_W-1:0] duty,
    input  wire cfg_t                    cfg,
    output result_t                      result
);

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    logic                    armed_reg, armed_next;
    logic                    expired_reg, expired_next;
    logic [TIMER_W-1:0]      elapsed_reg, elapsed_next;
    logic [TIMER_W-1:0]      since_stop_reg, since_stop_next;
    dir_t                    drive_dir_reg, drive_dir_next;
    dir_t                    last_dir_reg, last_dir_next;
    logic                    fault_reg, fault_next;
    logic                    enable_reg, enable_next;
    logic [DUTY_FIELD_W-1:0] right_reg, right_next;
    logic [DUTY_FIELD_W-1:0] left_reg, left_next;
    status_t                 status;
    logic                    do_stop;
    logic                    use_right;

    // Next state for one request
    always_comb begin
        armed_next      = armed_reg;
        expired_next    = expired_reg;
        elapsed_next    = elapsed_reg;
        since_stop_next = since_stop_reg;
        drive_dir_next  = drive_dir_reg;
        last_dir_next   = last_dir_reg;
        fault_next      = fault_reg;
        enable_next     = enable_reg;
        right_next      = right_reg;
        left_next       = left_reg;
        status          = STAT_NONE;
        do_stop         = 1'b0;
        use_right       = 1'b0;

        case (item.kind)
            KIND_TICK: begin
                if (since_stop_reg != TIMER_MAX) begin
                    since_stop_next = since_stop_reg + 1'b1;
                end
                if (armed_reg && elapsed_reg != TIMER_MAX) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
                // Latch expiry once the lease runs out
                if (armed_reg && !expired_reg && elapsed_next >= cfg.lease_timeout) begin
                    armed_next   = 1'b0;
                    expired_next = 1'b1;
                    fault_next   = 1'b1;
                    enable_next  = 1'b0;
                end
            end
            KIND_DRIVE: begin
                if (item.cmd_zero) begin
                    status  = STAT_APPLIED;
                    do_stop = 1'b1;
                end else if (fault_reg || expired_reg) begin
                    status  = STAT_REJECTED;
                    do_stop = 1'b1;
                end else if (drive_dir_reg != DIR_STOP && drive_dir_reg != item.dir) begin
                    status  = STAT_REJECTED;
                    do_stop = 1'b1;
                end else if (last_dir_reg != DIR_STOP && item.dir != last_dir_reg
                             && since_stop_reg < cfg.neutral_delay) begin
                    status  = STAT_WAIT_NEUTRAL;
                    do_stop = 1'b1;
                end else begin
                    // Apply: drive one side, renew the lease
                    status    = STAT_APPLIED;
                    use_right = (item.dir == DIR_FWD) ? cfg.fwd_rpwm : !cfg.fwd_rpwm;
                    if (use_right) begin
                        right_next = duty;
                        left_next  = '0;
                    end else begin
                        right_next = '0;
                        left_next  = duty;
                    end
                    elapsed_next   = '0;
                    armed_next     = 1'b1;
                    enable_next    = 1'b1;
                    drive_dir_next = item.dir;
                    last_dir_next  = item.dir;
                end
            end
            KIND_FAULT_STOP: begin
                fault_next = 1'b1;
                do_stop    = 1'b1;
            end
            KIND_CLEAR_FAULT: begin
                fault_next = expired_reg;
                do_stop    = 1'b1;
            end
            default: begin
                status = STAT_NONE;
            end
        endcase

        // Stop the bridge; restart the neutral timer only if a drive direction was set
        if (do_stop) begin
            enable_next    = 1'b0;
            armed_next     = 1'b0;
            right_next     = '0;
            left_next      = '0;
            drive_dir_next = DIR_STOP;
            if (drive_dir_reg != DIR_STOP) begin
                since_stop_next = '0;
            end
        end
    end

    // Hold state until a request fires
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg      <= 1'b0;
            expired_reg    <= 1'b0;
            elapsed_reg    <= '0;
            since_stop_reg <= '0;
            drive_dir_reg  <= DIR_STOP;
            last_dir_reg   <= DIR_STOP;
            fault_reg      <= 1'b0;
            enable_reg     <= 1'b0;
            right_reg      <= '0;
            left_reg       <= '0;
        end else if (fire) begin
            armed_reg      <= armed_next;
            expired_reg    <= expired_next;
            elapsed_reg    <= elapsed_next;
            since_stop_reg <= since_stop_next;
            drive_dir_reg  <= drive_dir_next;
            last_dir_reg   <= last_dir_next;
            fault_reg      <= fault_next;
            enable_reg     <= enable_next;
            right_reg      <= right_next;
            left_reg       <= left_next;
        end
    end

    // Result reflects the state after this request
    always_comb begin
        result.bridge_enable = enable_next;
        result.right_duty    = right_next;
        result.left_duty     = left_next;
        result.status        = status;
        result.expired_flag  = expired_next;
        result.fault_flag    = fault_next;
    end

endmodule

`default_nettype wire

### hdl/h_bridge_drive_safety_controller_top.sv
// Channel  Handshake                    Payload
// -------  ---------------------------  ------------------------------------------
// input    s_tvalid / s_tready          s_tuser: kind; s_tdata: drive_command
// result   m_tvalid / m_tready          m_tdata: enable, duties, status, flags
// config   cfg_valid / cfg_ready        cfg_index, cfg_data (always ready)
//
// One request per cycle unless the result stalls: input register, control
// logic, result register; m_tvalid rises as the result register takes the
// request. The command magnitude is scaled by DUTY_MAX before the input
// register. aresetn is synchronous; valid flags and controller state clear,
// configuration returns to defaults. A stalled result holds the result
// register and, once the input register is full, drops s_tready.
`default_nettype none

module h_bridge_drive_safety_controller_top
    import hbd_pkg::*;
#(
    parameter int DUTY_MAX = HBD_DUTY_MAX
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input requests
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [CMD_W-1:0]       s_tdata,   // [15:0] drive_command
    input  wire logic [1:0]             s_tuser,   // [1:0] kind
    // result requests
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [31:0]                 m_tdata,   // [0] bridge_enable, [10:1] right_duty,
                                                   // [20:11] left_duty, [22:21] status,
                                                   // [23] expired_flag, [24] fault_flag
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DUTY_W = $clog2(DUTY_MAX + 1);
    localparam int PROD_W = MAG_W + DUTY_W;

    localparam logic [CMD_W-1:0] CMD_MOST_NEG = {1'b1, {(CMD_W-1){1'b0}}};

    logic                    in_valid_reg;
    item_t                   item_reg, item_next;
    logic [PROD_W-1:0]       product_reg, product_next;
    logic [MAG_W-1:0]        mag;
    logic [CMD_W-1:0]        neg_cmd;
    logic                    advance;
    logic                    fire;
    logic                    out_valid_reg;
    result_t                 out_reg;
    result_t                 result;
    logic [DUTY_FIELD_W-1:0] duty;
    cfg_t                    cfg_reg;

    // Flow control: the result register empties or is taken
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign fire      = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    // Decode the command and scale its magnitude
    always_comb begin
        neg_cmd = ~s_tdata + 1'b1;
        if (s_tdata == CMD_MOST_NEG) begin
            mag = {MAG_W{1'b1}};
        end else if (s_tdata[CMD_W-1]) begin
            mag = neg_cmd[MAG_W-1:0];
        end else begin
            mag = s_tdata[MAG_W-1:0];
        end
        item_next.kind     = kind_t'(s_tuser);
        item_next.cmd_zero = (s_tdata == '0);
        item_next.dir      = s_tdata[CMD_W-1] ? DIR_REV : DIR_FWD;
        product_next       = PROD_W'(mag) * PROD_W'(DUTY_MAX);
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg    <= item_next;
            product_reg <= product_next;
        end
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fwd_rpwm      <= 1'b1;
            cfg_reg.lease_timeout <= TIMER_W'(200000);
            cfg_reg.neutral_delay <= TIMER_W'(250000);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_FWD_RPWM:      cfg_reg.fwd_rpwm      <= cfg_data[0];
                CFG_LEASE_TIMEOUT: cfg_reg.lease_timeout <= cfg_data[TIMER_W-1:0];
                CFG_NEUTRAL_DELAY: cfg_reg.neutral_delay <= cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hbd_duty_scale #(
        .DUTY_MAX(DUTY_MAX)
    ) u_duty_scale (
        .product(product_reg),
        .duty   (duty)
    );

    hbd_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .fire   (fire),
        .item   (item_reg),
        .duty   (duty),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_reg.fault_flag,
                       out_reg.expired_flag,
                       out_reg.status,
                       out_reg.left_duty,
                       out_reg.right_duty,
                       out_reg.bridge_enable};

endmodule

`default_nettype wire

### sim/h_bridge_drive_safety_controller_top_tb.sv
`default_nettype none

module h_bridge_drive_safety_controller_top_tb;
    import hbd_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [23:0] TIMER_MAX   = 24'hFFFFFF;

    typedef struct {
        kind_t       kind;
        logic [15:0] cmd;
    } bridge_req_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Block ports
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [CMD_W-1:0]       s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Stimulus and checking state
    bridge_req_t cmd_pending_q[$];
    result_t     bridge_state_q[$];
    bridge_req_t drv_req;
    result_t     acc_result;
    result_t     want_result;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          pressure_cycles = 0;
    int          held_cycles     = 0;
    int          cycle_cnt       = 0;
    int          result_cnt      = 0;
    int          mismatches      = 0;
    logic        gen_fwd         = 1'b1;

    // Predicted configuration, starting at reset defaults
    logic        fwd_rpwm_m      = 1'b1;
    logic [23:0] lease_timeout_m = 24'd200000;
    logic [23:0] neutral_delay_m = 24'd250000;

    // Predicted controller state
    logic        lease_armed   = 1'b0;
    logic        lease_expired = 1'b0;
    logic [23:0] lease_elapsed = '0;
    logic [23:0] since_stop    = '0;
    dir_t        drive_dir     = DIR_STOP;
    dir_t        last_dir      = DIR_STOP;
    logic        fault_latch   = 1'b0;
    logic        enable_q      = 1'b0;
    logic [9:0]  right_duty_q  = '0;
    logic [9:0]  left_duty_q   = '0;

    h_bridge_drive_safety_controller_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // De-energize the bridge; restart the neutral timer only if it was driving
    function automatic void bridge_stop();
        enable_q     = 1'b0;
        lease_armed  = 1'b0;
        right_duty_q = '0;
        left_duty_q  = '0;
        if (drive_dir != DIR_STOP)
            since_stop = '0;
        drive_dir = DIR_STOP;
    endfunction

    // Advance the bridge state by one request and return its status
    function automatic status_t predict_bridge(kind_t kind, logic [15:0] raw);
        status_t         st;
        int              cmd;
        int unsigned     mag;
        longint unsigned num;
        longint unsigned duty;
        dir_t            want_dir;
        logic            use_right;
        st = STAT_NONE;
        case (kind)
            KIND_TICK: begin
                if (since_stop != TIMER_MAX)
                    since_stop = since_stop + 1'b1;
                if (lease_armed && lease_elapsed != TIMER_MAX)
                    lease_elapsed = lease_elapsed + 1'b1;
                // Lease ran out: latch expiry and fault, drop enable, keep duties
                if (lease_armed && !lease_expired && lease_elapsed >= lease_timeout_m) begin
                    lease_armed   = 1'b0;
                    lease_expired = 1'b1;
                    fault_latch   = 1'b1;
                    enable_q      = 1'b0;
                end
            end
            KIND_DRIVE: begin
                cmd = int'($signed(raw));
                if (cmd < -FULL_SCALE)
                    cmd = -FULL_SCALE;
                want_dir = (cmd > 0) ? DIR_FWD : DIR_REV;
                if (cmd == 0) begin
                    bridge_stop();
                    st = STAT_APPLIED;
                end else if (fault_latch || lease_expired) begin
                    bridge_stop();
                    st = STAT_REJECTED;
                end else if (drive_dir != DIR_STOP && drive_dir != want_dir) begin
                    bridge_stop();
                    st = STAT_REJECTED;
                end else if (last_dir != DIR_STOP && want_dir != last_dir &&
                             since_stop < neutral_delay_m) begin
                    bridge_stop();
                    st = STAT_WAIT_NEUTRAL;
                end else begin
                    mag  = (cmd > 0) ? cmd : -cmd;
                    num  = longint'(mag) * HBD_DUTY_MAX * 2 + FULL_SCALE;
                    duty = num / (2 * FULL_SCALE);
                    if (duty > longint'(DUTY_FIELD_MAX))
                        duty = longint'(DUTY_FIELD_MAX);
                    use_right = (want_dir == DIR_FWD) ? fwd_rpwm_m : !fwd_rpwm_m;
                    right_duty_q  = use_right ? duty[9:0] : 10'd0;
                    left_duty_q   = use_right ? 10'd0 : duty[9:0];
                    lease_elapsed = '0;
                    lease_armed   = 1'b1;
                    enable_q      = 1'b1;
                    drive_dir     = want_dir;
                    last_dir      = want_dir;
                    st            = STAT_APPLIED;
                end
            end
            KIND_FAULT_STOP: begin
                fault_latch = 1'b1;
                bridge_stop();
            end
            default: begin
                bridge_stop();
                fault_latch = lease_expired;
            end
        endcase
        return st;
    endfunction

    // Random request: runs of one direction with stops, ticks and fault traffic
    function automatic bridge_req_t gen_request();
        bridge_req_t req;
        int unsigned roll;
        int unsigned mag;
        roll     = $urandom_range(99);
        req.cmd  = 16'($urandom);
        req.kind = KIND_TICK;
        if (roll >= 40 && roll < 88) begin
            req.kind = KIND_DRIVE;
            if ($urandom_range(9) == 0)
                gen_fwd = !gen_fwd;
            roll = $urandom_range(99);
            if (roll < 14)
                mag = 0;
            else if (roll < 22)
                mag = 32767;
            else
                mag = $urandom_range(32767, 1);
            req.cmd = gen_fwd ? mag[15:0] : 16'(0 - mag);
            if (roll >= 96)
                req.cmd = 16'h8000;
        end else if (roll >= 88 && roll < 93) begin
            req.kind = KIND_FAULT_STOP;
        end else if (roll >= 93) begin
            req.kind = KIND_CLEAR_FAULT;
        end
        return req;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("result %0d mismatch: %s", result_cnt, msg);
        mismatches++;
    endtask

    task automatic push_req(input kind_t kind, input logic [15:0] cmd);
        bridge_req_t req;
        req.kind = kind;
        req.cmd  = cmd;
        cmd_pending_q.push_back(req);
    endtask

    task automatic push_random(input int n);
        repeat (n) cmd_pending_q.push_back(gen_request());
    endtask

    // Wait until every request is sent and answered, then let the pipeline settle;
    // sample between edges so the driver's updates have landed
    task automatic drain();
        do @(negedge aclk);
        while (cmd_pending_q.size() != 0 || s_tvalid || bridge_state_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_FWD_RPWM:      fwd_rpwm_m = val[0];
            CFG_LEASE_TIMEOUT: lease_timeout_m = val;
            CFG_NEUTRAL_DELAY: neutral_delay_m = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge aclk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Request driver: predict on accept, then offer the next pending request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                acc_result.status        = predict_bridge(kind_t'(s_tuser), s_tdata);
                acc_result.bridge_enable = enable_q;
                acc_result.right_duty    = right_duty_q;
                acc_result.left_duty     = left_duty_q;
                acc_result.expired_flag  = lease_expired;
                acc_result.fault_flag    = fault_latch;
                bridge_state_q.push_back(acc_result);
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_req = cmd_pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= drv_req.kind;
                    s_tdata  <= drv_req.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver backpressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (bridge_state_q.size() == 0) begin
                log_mismatch($sformatf("unexpected result 0x%08h", m_tdata));
            end else begin
                want_result = bridge_state_q.pop_front();
                if (m_tdata[0] !== want_result.bridge_enable)
                    log_mismatch($sformatf("bridge_enable got %0b want %0b",
                                           m_tdata[0], want_result.bridge_enable));
                if (m_tdata[10:1] !== want_result.right_duty)
                    log_mismatch($sformatf("right_duty got %0d want %0d",
                                           m_tdata[10:1], want_result.right_duty));
                if (m_tdata[20:11] !== want_result.left_duty)
                    log_mismatch($sformatf("left_duty got %0d want %0d",
                                           m_tdata[20:11], want_result.left_duty));
                if (m_tdata[22:21] !== want_result.status)
                    log_mismatch($sformatf("status got %0d want %0d",
                                           m_tdata[22:21], want_result.status));
                if (m_tdata[23] !== want_result.expired_flag)
                    log_mismatch($sformatf("expired_flag got %0b want %0b",
                                           m_tdata[23], want_result.expired_flag));
                if (m_tdata[24] !== want_result.fault_flag)
                    log_mismatch($sformatf("fault_flag got %0b want %0b",
                                           m_tdata[24], want_result.fault_flag));
            end
            result_cnt++;
        end
        // Hold off for a long stretch when asked, else stall at random
        if (pressure_cycles != 0 && held_cycles < pressure_cycles) begin
            held_cycles <= held_cycles + 1;
            m_tready    <= 1'b0;
        end else begin
            if (pressure_cycles == 0)
                held_cycles <= 0;
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: every command kind, rejects and neutral hold
        push_req(KIND_TICK, 16'h0000);
        push_req(KIND_DRIVE, 16'h7FFF);
        push_req(KIND_DRIVE, 16'd16384);
        push_req(KIND_DRIVE, 16'hFFFF);
        push_req(KIND_DRIVE, 16'h8000);
        push_req(KIND_DRIVE, 16'd1);
        push_req(KIND_DRIVE, 16'h0000);
        push_req(KIND_TICK, 16'hFFFF);
        push_req(KIND_FAULT_STOP, 16'h1234);
        push_req(KIND_DRIVE, 16'd100);
        push_req(KIND_CLEAR_FAULT, 16'h8000);
        push_req(KIND_DRIVE, 16'h8001);
        push_req(KIND_DRIVE, 16'd16);
        drain();

        // Forward on left PWM, no neutral wait: full reverse and clamped minimum
        write_reg(CFG_FWD_RPWM, 24'd0);
        write_reg(CFG_NEUTRAL_DELAY, 24'd0);
        push_req(KIND_DRIVE, 16'h8000);
        push_req(KIND_DRIVE, 16'h8000);
        push_req(KIND_DRIVE, 16'h8001);
        push_req(KIND_TICK, 16'h0000);
        push_req(KIND_DRIVE, 16'h7FFF);
        push_req(KIND_DRIVE, 16'h7FFF);
        drain();

        // Long lease, short neutral delay, no idling
        write_reg(CFG_FWD_RPWM, 24'd1);
        write_reg(CFG_LEASE_TIMEOUT, TIMER_MAX);
        write_reg(CFG_NEUTRAL_DELAY, 24'($urandom_range(30, 2)));
        push_random(150);
        drain();

        // Sender idling
        write_reg(CFG_FWD_RPWM, 24'd0);
        write_reg(CFG_NEUTRAL_DELAY, 24'd0);
        set_idling(60, 0);
        push_random(150);
        drain();

        // Receiver stalling, reversal never allowed
        write_reg(CFG_FWD_RPWM, 24'd1);
        write_reg(CFG_NEUTRAL_DELAY, TIMER_MAX);
        set_idling(0, 60);
        push_random(100);
        drain();

        // Both sides idling
        write_reg(CFG_FWD_RPWM, 24'($urandom_range(1, 0)));
        write_reg(CFG_NEUTRAL_DELAY, 24'($urandom_range(20, 1)));
        set_idling(26, 26);
        push_random(150);
        drain();

        // Long receiver hold while the sender keeps offering
        set_idling(0, 0);
        @(posedge aclk);
        pressure_cycles <= 300;
        push_random(120);
        drain();
        pressure_cycles <= 0;

        // Zero lease timeout expires on the first tick; expiry sticks
        write_reg(CFG_LEASE_TIMEOUT, 24'd0);
        push_req(KIND_DRIVE, 16'd500);
        push_req(KIND_TICK, 16'h0000);
        push_req(KIND_TICK, 16'h0000);
        push_req(KIND_CLEAR_FAULT, 16'h0000);
        push_req(KIND_DRIVE, 16'd700);
        push_req(KIND_FAULT_STOP, 16'h0000);
        push_req(KIND_CLEAR_FAULT, 16'h0000);
        push_req(KIND_DRIVE, 16'h0000);
        drain();

        // Lease timeout of one with light neutral delay after expiry
        write_reg(CFG_LEASE_TIMEOUT, 24'd1);
        write_reg(CFG_NEUTRAL_DELAY, 24'd5);
        set_idling(26, 26);
        push_random(60);
        drain();

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && bridge_state_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
